FILE: rtl/lsq_pkg.sv
// Package for the least-squares line fit block: widths, codes, the command
// record passed from the front queue to the back end and the result record.
// No dependencies.
`timescale 1ns / 1ps

package lsq_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_POINTS = 4096;
    localparam int DEF_FRAC_BITS  = 8;

    // Field and accumulator widths
    localparam int SAMPLE_W = 16;
    localparam int SXX_W    = 48;
    localparam int SX_W     = 32;
    localparam int RES_W    = 32;
    localparam int ERR_W    = 2;
    localparam int WIDE_W   = 128;  // working width of the solver
    localparam int MULB_W   = 64;   // multiplier operand width of the MAC

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SINGULAR = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DROPPED  = 2'd2;

    typedef struct packed {
        logic                       is_query;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
    } cmd_t;

    typedef struct packed {
        logic [ERR_W-1:0] error_code;
        logic [RES_W-1:0] fitted_value;
        logic [RES_W-1:0] intercept;
        logic [RES_W-1:0] slope;
    } result_t;

endpackage

FILE: rtl/lsq_queue.sv
// Front end: accepts input requests, classifies them and queues them.
// Depends on lsq_pkg.
`timescale 1ns / 1ps

module lsq_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // x_value, y_value
    input  logic                              s_axis_tuser,  // opcode
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output lsq_pkg::cmd_t                     cmd
);
    import lsq_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    cmd_t              in_cmd;

    // Classify the incoming request
    always_comb begin
        in_cmd.is_query = (s_axis_tuser == OP_QUERY);
        in_cmd.x        = s_axis_tdata[15:0];
        in_cmd.y        = s_axis_tdata[31:16];
    end

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid     = (count_reg != '0);
    assign cmd           = mem[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = cmd_valid && cmd_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill not incremented on push");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue fill not decremented on pop");

endmodule

FILE: rtl/lsq_mac.sv
// Shift-add multiply-accumulate unit: acc = acc_init +/- mcand * mplier,
// one multiplier bit per cycle, two's complement, modulo 2^WIDE_W.
// Depends on lsq_pkg.
`timescale 1ns / 1ps

module lsq_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          sub,
    input  logic [lsq_pkg::WIDE_W-1:0]    acc_init,
    input  logic [lsq_pkg::WIDE_W-1:0]    mcand,
    input  logic [lsq_pkg::MULB_W-1:0]    mplier,
    output logic                          busy,
    output logic                          done,
    output logic [lsq_pkg::WIDE_W-1:0]    acc
);
    import lsq_pkg::*;

    localparam int CNT_W = $clog2(MULB_W);

    logic [WIDE_W-1:0] acc_reg, mcand_reg;
    logic [MULB_W-1:0] mplier_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg, sub_reg;
    logic              last, negate;
    logic [WIDE_W-1:0] term, acc_next;

    // Sign bit of the multiplier carries negative weight
    always_comb begin
        last     = (cnt_reg == CNT_W'(MULB_W - 1));
        negate   = sub_reg ^ last;
        term     = mplier_reg[0] ? mcand_reg : '0;
        acc_next = acc_reg + (negate ? (~term + WIDE_W'(1)) : term);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= acc_init;
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            sub_reg    <= sub;
            cnt_reg    <= '0;
        end else if (busy_reg) begin
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg + 1'b1;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign acc  = acc_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("MAC started while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("MAC done while still busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && last) |=> done_reg)
        else $error("MAC finished without done pulse");

endmodule

FILE: rtl/lsq_div.sv
// Restoring divider, one quotient bit per cycle: trunc(num / den) saturated
// to a signed 32-bit result; den is positive and held by the caller.
// Depends on lsq_pkg.
`timescale 1ns / 1ps

module lsq_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lsq_pkg::WIDE_W-1:0]    num,
    input  logic [lsq_pkg::WIDE_W-1:0]    den,
    output logic                          busy,
    output logic                          done,
    output logic [lsq_pkg::RES_W-1:0]     quot
);
    import lsq_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W);

    logic [WIDE_W-1:0] n_reg, rem_reg;
    logic [RES_W:0]    q_reg;
    logic              big_reg, neg_reg, busy_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WIDE_W:0]   shifted, diff;
    logic              ge, last;

    // One restoring step
    always_comb begin
        shifted = {rem_reg, n_reg[WIDE_W-1]};
        diff    = shifted - {1'b0, den};
        ge      = (shifted >= {1'b0, den});
        last    = (cnt_reg == CNT_W'(WIDE_W - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[WIDE_W-1];
            n_reg   <= num[WIDE_W-1] ? (~num + WIDE_W'(1)) : num;
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            n_reg   <= n_reg << 1;
            rem_reg <= ge ? diff[WIDE_W-1:0] : shifted[WIDE_W-1:0];
            q_reg   <= {q_reg[RES_W-1:0], ge};
            big_reg <= big_reg | q_reg[RES_W];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Sign and saturation
    always_comb begin
        if (neg_reg) begin
            if (big_reg || (q_reg > {2'b01, {(RES_W-1){1'b0}}})) begin
                quot = {1'b1, {(RES_W-1){1'b0}}};
            end else begin
                quot = ~q_reg[RES_W-1:0] + RES_W'(1);
            end
        end else begin
            if (big_reg || q_reg[RES_W] || q_reg[RES_W-1]) begin
                quot = {1'b0, {(RES_W-1){1'b1}}};
            end else begin
                quot = q_reg[RES_W-1:0];
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (den != '0))
        else $error("divider running with zero divisor");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && last) |=> done_reg)
        else $error("divider finished without done pulse");

endmodule

FILE: rtl/lsq_back.sv
// Back end: running sums for add requests and the query sequencer that
// solves the normal equations with the shared MAC and divider.
// Depends on lsq_pkg, lsq_mac and lsq_div.
`timescale 1ns / 1ps

module lsq_back #(
    parameter int MAX_POINTS = lsq_pkg::DEF_MAX_POINTS,
    parameter int FRAC_BITS  = lsq_pkg::DEF_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  lsq_pkg::cmd_t        cmd,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lsq_pkg::result_t     res
);
    import lsq_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SHIFT = 16 - FRAC_BITS;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    // Sequencer steps
    localparam logic [3:0] STEP_D_POS   = 4'd0;
    localparam logic [3:0] STEP_D_NEG   = 4'd1;
    localparam logic [3:0] STEP_DA_POS  = 4'd2;
    localparam logic [3:0] STEP_DA_NEG  = 4'd3;
    localparam logic [3:0] STEP_DB_POS  = 4'd4;
    localparam logic [3:0] STEP_DB_NEG  = 4'd5;
    localparam logic [3:0] STEP_FIT     = 4'd6;
    localparam logic [3:0] STEP_DIV_A   = 4'd7;
    localparam logic [3:0] STEP_DIV_B   = 4'd8;
    localparam logic [3:0] STEP_DIV_FIT = 4'd9;

    logic signed [SXX_W-1:0]    sxx_reg, sxy_reg;
    logic signed [SX_W-1:0]     sx_reg, sy_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       ovf_reg;
    logic [1:0]                 state_reg;
    logic [3:0]                 step_reg;
    logic                       issue_reg;
    logic signed [SAMPLE_W-1:0] qx_reg;
    logic [WIDE_W-1:0]          d_reg, da_reg, db_reg, fit_reg;
    logic [RES_W-1:0]           slope_reg, icpt_reg, fitv_reg;
    logic                       sing_reg;
    logic                       res_valid_reg;
    result_t                    res_reg;

    logic                       take, full;
    logic signed [2*SAMPLE_W-1:0] xx, xy;
    logic                       mac_start, mac_sub, mac_busy, mac_done;
    logic [WIDE_W-1:0]          mac_init, mac_mcand, mac_acc;
    logic [MULB_W-1:0]          mac_mplier;
    logic                       div_start, div_busy, div_done;
    logic [WIDE_W-1:0]          div_num;
    logic [RES_W-1:0]           div_quot;
    logic [WIDE_W-1:0]          n_w, sxx_w, sx_w, sxy_w, sy_w;
    logic                       out_free;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign full      = (count_reg == CNT_W'(MAX_POINTS));
    assign xx        = cmd.x * cmd.x;
    assign xy        = cmd.x * cmd.y;
    assign out_free  = !res_valid_reg || res_ready;

    // Widened operands: point count zero-extended, sums sign-extended
    always_comb begin
        n_w   = WIDE_W'(count_reg);
        sxx_w = WIDE_W'(signed'(sxx_reg));
        sx_w  = WIDE_W'(signed'(sx_reg));
        sxy_w = WIDE_W'(signed'(sxy_reg));
        sy_w  = WIDE_W'(signed'(sy_reg));
    end

    // Unit issue for the current step
    always_comb begin
        mac_start  = 1'b0;
        mac_sub    = 1'b0;
        mac_init   = '0;
        mac_mcand  = '0;
        mac_mplier = '0;
        div_start  = 1'b0;
        div_num    = '0;
        if (state_reg == ST_RUN && issue_reg) begin
            unique case (step_reg)
                STEP_D_POS: begin
                    mac_start = 1'b1; mac_mcand = n_w; mac_mplier = sxx_w[MULB_W-1:0];
                end
                STEP_D_NEG: begin
                    mac_start = 1'b1; mac_sub = 1'b1; mac_init = mac_acc;
                    mac_mcand = sx_w; mac_mplier = sx_w[MULB_W-1:0];
                end
                STEP_DA_POS: begin
                    mac_start = 1'b1; mac_mcand = n_w; mac_mplier = sxy_w[MULB_W-1:0];
                end
                STEP_DA_NEG: begin
                    mac_start = 1'b1; mac_sub = 1'b1; mac_init = mac_acc;
                    mac_mcand = sx_w; mac_mplier = sy_w[MULB_W-1:0];
                end
                STEP_DB_POS: begin
                    mac_start = 1'b1; mac_mcand = sxx_w; mac_mplier = sy_w[MULB_W-1:0];
                end
                STEP_DB_NEG: begin
                    mac_start = 1'b1; mac_sub = 1'b1; mac_init = mac_acc;
                    mac_mcand = sxy_w; mac_mplier = sx_w[MULB_W-1:0];
                end
                STEP_FIT: begin
                    mac_start = 1'b1; mac_init = mac_acc; mac_mcand = da_reg;
                    mac_mplier = MULB_W'(qx_reg);
                end
                STEP_DIV_A: begin
                    div_start = 1'b1; div_num = da_reg << 16;
                end
                STEP_DIV_B: begin
                    div_start = 1'b1; div_num = db_reg << SHIFT;
                end
                STEP_DIV_FIT: begin
                    div_start = 1'b1; div_num = fit_reg << SHIFT;
                end
                default: begin
                end
            endcase
        end
    end

    lsq_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mac_start),
        .sub      (mac_sub),
        .acc_init (mac_init),
        .mcand    (mac_mcand),
        .mplier   (mac_mplier),
        .busy     (mac_busy),
        .done     (mac_done),
        .acc      (mac_acc)
    );

    lsq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (d_reg),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Accumulators and sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sxx_reg   <= '0;
            sx_reg    <= '0;
            sxy_reg   <= '0;
            sy_reg    <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            state_reg <= ST_IDLE;
            step_reg  <= STEP_D_POS;
            issue_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (take && !cmd.is_query) begin
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            sxx_reg   <= sxx_reg + SXX_W'(xx);
                            sxy_reg   <= sxy_reg + SXX_W'(xy);
                            sx_reg    <= sx_reg + SX_W'(cmd.x);
                            sy_reg    <= sy_reg + SX_W'(cmd.y);
                            count_reg <= count_reg + 1'b1;
                        end
                    end else if (take) begin
                        state_reg <= ST_RUN;
                        step_reg  <= STEP_D_POS;
                        issue_reg <= 1'b1;
                    end
                end
                ST_RUN: begin
                    if (issue_reg) begin
                        issue_reg <= 1'b0;
                    end else if (mac_done || div_done) begin
                        issue_reg <= 1'b1;
                        step_reg  <= step_reg + 1'b1;
                        if (step_reg == STEP_D_NEG &&
                            (mac_acc[WIDE_W-1] || mac_acc == '0)) begin
                            state_reg <= ST_OUT;
                            issue_reg <= 1'b0;
                        end else if (step_reg == STEP_DIV_FIT) begin
                            state_reg <= ST_OUT;
                            issue_reg <= 1'b0;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Intermediate results of a query
    always_ff @(posedge aclk) begin
        if (take && cmd.is_query) begin
            qx_reg   <= cmd.x;
            sing_reg <= 1'b0;
        end
        if (state_reg == ST_RUN && !issue_reg && (mac_done || div_done)) begin
            unique case (step_reg)
                STEP_D_NEG: begin
                    d_reg    <= mac_acc;
                    sing_reg <= mac_acc[WIDE_W-1] || (mac_acc == '0);
                end
                STEP_DA_NEG:  da_reg    <= mac_acc;
                STEP_DB_NEG:  db_reg    <= mac_acc;
                STEP_FIT:     fit_reg   <= mac_acc;
                STEP_DIV_A:   slope_reg <= div_quot;
                STEP_DIV_B:   icpt_reg  <= div_quot;
                STEP_DIV_FIT: fitv_reg  <= div_quot;
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            res_valid_reg <= 1'b1;
        end else if (res_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            if (sing_reg) begin
                res_reg.slope        <= '0;
                res_reg.intercept    <= '0;
                res_reg.fitted_value <= '0;
                res_reg.error_code   <= ERR_SINGULAR;
            end else begin
                res_reg.slope        <= slope_reg;
                res_reg.intercept    <= icpt_reg;
                res_reg.fitted_value <= fitv_reg;
                res_reg.error_code   <= ovf_reg ? ERR_DROPPED : ERR_OK;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above store size");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!mac_busy && !div_busy))
        else $error("arithmetic unit busy while sequencer idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mac_start && div_start))
        else $error("MAC and divider issued together");
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !sing_reg)
        else $error("division issued for singular system");

endmodule

FILE: rtl/least_squares_line_fit.sv
// Least-squares line fit y = a*x + b over a stream of Q8.8 sample points.
// Input stream: tuser is the opcode (0 add a point, 1 query), tdata carries
// x_value in [15:0] and y_value in [31:16]. An add request yields nothing;
// a query yields one result on the output stream: slope [31:0], intercept
// [63:32], fitted value [95:64] (all Q16.16, saturated) and error code
// [97:96] (0 ok, 1 singular, 2 points dropped once the store filled).
// A four-entry command queue separates the input from the solver.
// Add requests retire at one per cycle while no query is in progress. A query
// runs seven shift-add MAC steps (each: issue, 64 multiplier bits, done) and
// three restoring divider steps (each: issue, 128 bits, done); a singular
// system ends the query once the determinant is known. Requests behind it
// wait in the queue.
// Synchronous active-low reset clears the sums, point count, dropped flag,
// queue and output valid flag; the block starts with no points.
// While the receiver stalls, a finished result waits in the output register;
// adds keep retiring, and the next query holds at its output step.
// Depends on lsq_pkg, lsq_queue, lsq_back.
`timescale 1ns / 1ps

module least_squares_line_fit #(
    parameter int MAX_POINTS = lsq_pkg::DEF_MAX_POINTS,
    parameter int FRAC_BITS  = lsq_pkg::DEF_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // x_value, y_value
    input  logic         s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // slope, intercept, fitted_value, error_code
);
    import lsq_pkg::*;

    logic    cmd_valid, cmd_ready;
    cmd_t    cmd;
    result_t res;

    lsq_queue u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    lsq_back #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack result fields, padded to whole bytes
    assign m_axis_tdata = {6'd0, res};

endmodule

FILE: test/least_squares_line_fit_check.sv
// Checker for the least-squares line fit block: watches both streams, keeps
// its own running sums, predicts each query result and compares field by field.
// Depends on lsq_pkg.
`timescale 1ns / 1ps

module least_squares_line_fit_check #(
    parameter int MAX_POINTS = lsq_pkg::DEF_MAX_POINTS,
    parameter int FRAC_BITS  = lsq_pkg::DEF_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    output int           fail_count,
    output int           pending_fits
);
    import lsq_pkg::*;

    // Running sums of the accepted points
    logic signed [63:0] acc_xx, acc_x, acc_xy, acc_y;
    int unsigned        n_points;
    logic               dropped;

    result_t fit_q[$];

    assign pending_fits = fit_q.size();

    // Truncating divide with saturation to 32 bits; den > 0
    function automatic logic [31:0] div_sat(logic signed [159:0] num,
                                            logic signed [159:0] den);
        logic signed [159:0] q;
        q = num / den;
        if (q > 160'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (q < -160'sh80000000) return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic result_t solve_fit(logic signed [15:0] qx);
        logic signed [159:0] nn, d, da, db, fit;
        result_t r;
        nn = $signed({1'b0, n_points});
        d  = nn * acc_xx - acc_x * acc_x;
        r.error_code = dropped ? ERR_DROPPED : ERR_OK;
        if (d <= 0) begin
            r.slope = '0; r.intercept = '0; r.fitted_value = '0;
            r.error_code = ERR_SINGULAR;
            return r;
        end
        da  = nn * acc_xy - acc_x * acc_y;
        db  = acc_xx * acc_y - acc_xy * acc_x;
        fit = da * qx + db;
        r.slope        = div_sat(da <<< 16, d);
        r.intercept    = div_sat(db <<< (16 - FRAC_BITS), d);
        r.fitted_value = div_sat(fit <<< (16 - FRAC_BITS), d);
        return r;
    endfunction

    always @(posedge aclk) begin
        logic signed [15:0] px, py;
        result_t got, want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            acc_xx <= 0; acc_x <= 0; acc_xy <= 0; acc_y <= 0;
            n_points <= 0; dropped <= 0; fail_count <= 0;
            fit_q.delete();
        end else begin
            // Output side first: a query result never leaves in its own cycle
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[97:0];
                if (fit_q.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    errs++;
                end else begin
                    want = fit_q.pop_front();
                    if (got.slope !== want.slope) begin
                        $error("slope exp %h got %h", want.slope, got.slope);
                        errs++;
                    end
                    if (got.intercept !== want.intercept) begin
                        $error("intercept exp %h got %h", want.intercept, got.intercept);
                        errs++;
                    end
                    if (got.fitted_value !== want.fitted_value) begin
                        $error("fitted_value exp %h got %h",
                               want.fitted_value, got.fitted_value);
                        errs++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $error("error_code exp %0d got %0d",
                               want.error_code, got.error_code);
                        errs++;
                    end
                end
            end
            if (errs != 0) begin
                fail_count <= fail_count + errs;
            end
            // Input side
            if (s_axis_tvalid && s_axis_tready) begin
                px = s_axis_tdata[15:0];
                py = s_axis_tdata[31:16];
                if (s_axis_tuser == OP_QUERY) begin
                    fit_q.push_back(solve_fit(px));
                end else if (n_points < MAX_POINTS) begin
                    acc_xx   <= acc_xx + px * px;
                    acc_x    <= acc_x + px;
                    acc_xy   <= acc_xy + px * py;
                    acc_y    <= acc_y + py;
                    n_points <= n_points + 1;
                end else begin
                    dropped <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: test/least_squares_line_fit_test.sv
// Testbench top for the least-squares line fit block: resets once, streams
// directed and random add/query requests with random idling, gives the verdict.
// Depends on lsq_pkg, least_squares_line_fit, least_squares_line_fit_check.
`timescale 1ns / 1ps

module least_squares_line_fit_test;
    import lsq_pkg::*;

    localparam int LIMIT = 6_000_000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [103:0] m_axis_tdata;
    int           fail_count, pending_fits;
    int           cycles = 0;
    bit           busy_phase = 1;   // random idling on/off

    always #5 aclk = ~aclk;

    least_squares_line_fit dut (.*);
    least_squares_line_fit_check check (.*);

    // Receiver stalls
    always @(negedge aclk)
        m_axis_tready <= !busy_phase || ($urandom_range(99) >= 32);

    // Run-time guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Send one request, with an optional idle gap before it
    task automatic send_req(logic op, logic [15:0] px, logic [15:0] py);
        while (busy_phase && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {py, px};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_val();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(7))
                                            : 16'(16'h8000 + $urandom_range(7));
            default: return 16'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    initial begin
        int k;
        repeat (7) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: empty fit, one point, equal x, then extremes
        send_req(OP_QUERY, 16'h0100, 16'hFFFF);
        send_req(OP_ADD, 16'h0100, 16'h0200);
        send_req(OP_QUERY, 16'h0000, 16'h0000);
        send_req(OP_ADD, 16'h0100, 16'h8000);
        send_req(OP_QUERY, 16'h7FFF, 16'h0000);
        send_req(OP_ADD, 16'h7FFF, 16'h7FFF);
        send_req(OP_ADD, 16'h8000, 16'h8000);
        send_req(OP_ADD, 16'h0001, 16'h7FFF);
        send_req(OP_QUERY, 16'h8000, 16'h1234);
        send_req(OP_QUERY, 16'h7FFF, 16'hFFFF);
        send_req(OP_ADD, 16'hFFFF, 16'h0000);
        send_req(OP_QUERY, 16'hFFFF, 16'h0000);

        // Random: mostly adds, with queries sprinkled in; no idling for a stretch
        for (k = 0; k < 1228; k++) begin
            busy_phase = !(k >= 300 && k < 500);
            send_req($urandom_range(99) < 6, pick_val(), pick_val());
        end

        busy_phase = 1;
        for (k = 0; k < 10; k++)
            send_req(1'($urandom_range(1)), pick_val(), pick_val());
        s_axis_tvalid <= 0;

        while (pending_fits != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/lsq_pkg.sv
rtl/lsq_queue.sv
rtl/lsq_mac.sv
rtl/lsq_div.sv
rtl/lsq_back.sv
rtl/least_squares_line_fit.sv
test/least_squares_line_fit_check.sv
test/least_squares_line_fit_test.sv
